// ===== design/tcce_pkg.sv =====
`default_nettype none

package tcce_pkg;

  // screen geometry
  localparam int SCREEN_COLS = 80;
  localparam int SCREEN_ROWS = 25;
  localparam int CELLS       = SCREEN_COLS * SCREEN_ROWS;
  localparam int COPY_CELLS  = (SCREEN_ROWS - 1) * SCREEN_COLS;
  localparam int ADDR_W      = $clog2(CELLS);
  localparam int CNT_W       = $clog2(CELLS + 1);

  // field widths
  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int CW_W     = COL_W + 1;
  localparam int ROWS_W   = ROW_W + 1;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = CHAR_W + ATTR_W;
  localparam int ACTION_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // character handling
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'd8;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
  localparam int TAB_STOP  = 4;
  localparam int TAB_SHIFT = $clog2(TAB_STOP);

  localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;
  localparam logic [CELL_W-1:0] RESET_CELL = {RESET_ATTR, SPACE_CHAR};

  // action codes
  localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MARGIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANK_ATTR   = 2'd2;

  // command queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_NOP   = 2'd0,
    CMD_PUT   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_kind_t;

  // classified work item passed from front to back
  typedef struct packed {
    cmd_kind_t           kind;
    logic                we;
    logic [ADDR_W-1:0]   addr;
    logic [CELL_W-1:0]   wdata;
    logic                scroll;
    logic [COL_W-1:0]    col;
    logic [ROW_W-1:0]    row;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/tcce_if.sv =====
`default_nettype none

interface tcce_req_if;
  logic                             valid;
  logic                             ready;
  logic [tcce_pkg::ACTION_W-1:0]    action;
  logic [tcce_pkg::CHAR_W-1:0]      char_code;
  logic [tcce_pkg::ATTR_W-1:0]      color;
  logic [tcce_pkg::ROW_W-1:0]       read_row;
  logic [tcce_pkg::COL_W-1:0]       read_col;

  modport source(output valid, action, char_code, color, read_row, read_col, input ready);
  modport sink(input valid, action, char_code, color, read_row, read_col, output ready);
endinterface

interface tcce_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [tcce_pkg::CELL_W-1:0]      cell_value;
  logic [tcce_pkg::COL_W-1:0]       cursor_col;
  logic [tcce_pkg::ROW_W-1:0]       cursor_row;
  logic                             scrolled;

  modport source(output valid, cell_value, cursor_col, cursor_row, scrolled, input ready);
  modport sink(input valid, cell_value, cursor_col, cursor_row, scrolled, output ready);
endinterface

interface tcce_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [tcce_pkg::CFG_IDX_W-1:0]     index;
  logic [tcce_pkg::CFG_DATA_W-1:0]    data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/tcce_front.sv =====
`default_nettype none

// Accepts items, tracks the cursor and turns each item into a command.
module tcce_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tcce_pkg::COL_W-1:0]    left_margin,
  input  logic [tcce_pkg::ATTR_W-1:0]   default_attr,
  input  logic                          q_full,
  input  logic                          init_done,
  tcce_req_if.sink                      req,
  output logic                          push,
  output tcce_pkg::cmd_t                cmd
);

  logic [tcce_pkg::COL_W-1:0]  col;
  logic [tcce_pkg::ROW_W-1:0]  row;
  logic [tcce_pkg::COL_W-1:0]  col_next;
  logic [tcce_pkg::ROW_W-1:0]  row_next;

  logic [tcce_pkg::CW_W-1:0]   cw;
  logic [tcce_pkg::CW_W-1:0]   ncol;
  logic [tcce_pkg::COL_W-1:0]  wcol;
  logic                        inc;
  logic [tcce_pkg::ROWS_W-1:0] rsum;

  assign req.ready = !q_full && init_done;
  assign push      = req.valid && req.ready;

  always_comb begin
    cw         = {1'b0, col};
    ncol       = cw;
    wcol       = col;
    inc        = 1'b0;
    rsum       = '0;
    cmd.kind   = tcce_pkg::CMD_NOP;
    cmd.we     = 1'b0;
    cmd.addr   = '0;
    cmd.wdata  = '0;
    cmd.scroll = 1'b0;
    col_next   = col;
    row_next   = row;

    unique case (req.action)
      tcce_pkg::ACT_PUT: begin
        cmd.kind = tcce_pkg::CMD_PUT;
        priority if (req.char_code == tcce_pkg::CH_TAB) begin
          ncol = ((cw >> tcce_pkg::TAB_SHIFT) + tcce_pkg::CW_W'(1)) << tcce_pkg::TAB_SHIFT;
        end else if (req.char_code == tcce_pkg::CH_CR) begin
          ncol = '0;
        end else if (req.char_code == tcce_pkg::CH_LF) begin
          ncol = '0;
          inc  = 1'b1;
        end else if (req.char_code == tcce_pkg::CH_BS) begin
          // blank left of the cursor; at or left of the margin the blank lands under it
          cmd.we    = 1'b1;
          cmd.wdata = {default_attr, tcce_pkg::SPACE_CHAR};
          priority if (col > left_margin) begin
            wcol = col - tcce_pkg::COL_W'(1);
            ncol = cw - tcce_pkg::CW_W'(1);
          end else if (cw == tcce_pkg::CW_W'(tcce_pkg::SCREEN_COLS - 1)) begin
            ncol = tcce_pkg::CW_W'(tcce_pkg::SCREEN_COLS);
          end else if (col == left_margin) begin
            ncol = cw;
          end else begin
            ncol = cw + tcce_pkg::CW_W'(1);
          end
        end else if (req.char_code >= tcce_pkg::SPACE_CHAR) begin
          cmd.we    = 1'b1;
          cmd.wdata = {req.color, req.char_code};
          ncol      = cw + tcce_pkg::CW_W'(1);
        end else begin
          ncol = cw;
        end

        // wrap to the next line
        if (ncol >= tcce_pkg::CW_W'(tcce_pkg::SCREEN_COLS)) begin
          ncol = '0;
          inc  = 1'b1;
        end
        rsum = {1'b0, row} + tcce_pkg::ROWS_W'(inc);
        if (rsum >= tcce_pkg::ROWS_W'(tcce_pkg::SCREEN_ROWS)) begin
          cmd.scroll = 1'b1;
          row_next   = tcce_pkg::ROW_W'(tcce_pkg::SCREEN_ROWS - 1);
        end else begin
          row_next   = rsum[tcce_pkg::ROW_W-1:0];
        end
        col_next = ncol[tcce_pkg::COL_W-1:0];
        cmd.addr = tcce_pkg::ADDR_W'(row) * tcce_pkg::ADDR_W'(tcce_pkg::SCREEN_COLS)
                 + tcce_pkg::ADDR_W'(wcol);
      end
      tcce_pkg::ACT_CLEAR: begin
        cmd.kind = tcce_pkg::CMD_CLEAR;
        col_next = '0;
        row_next = '0;
      end
      tcce_pkg::ACT_READ: begin
        if (req.read_row < tcce_pkg::ROW_W'(tcce_pkg::SCREEN_ROWS) &&
            req.read_col < tcce_pkg::COL_W'(tcce_pkg::SCREEN_COLS)) begin
          cmd.kind = tcce_pkg::CMD_READ;
          cmd.addr = tcce_pkg::ADDR_W'(req.read_row) * tcce_pkg::ADDR_W'(tcce_pkg::SCREEN_COLS)
                   + tcce_pkg::ADDR_W'(req.read_col);
        end
      end
      default: begin
        cmd.kind = tcce_pkg::CMD_NOP;
      end
    endcase

    cmd.col = col_next;
    cmd.row = row_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (push) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/tcce_queue.sv =====
`default_nettype none

// Small command queue between front and back.
module tcce_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tcce_pkg::cmd_t  din,
  output logic            full,
  input  logic            pop,
  output tcce_pkg::cmd_t  dout,
  output logic            empty
);

  tcce_pkg::cmd_t               entries [tcce_pkg::QDEPTH];
  logic [tcce_pkg::QPTR_W-1:0]  wr_ptr;
  logic [tcce_pkg::QPTR_W-1:0]  rd_ptr;
  logic [tcce_pkg::QCNT_W-1:0]  count;

  assign full  = (count == tcce_pkg::QCNT_W'(tcce_pkg::QDEPTH));
  assign empty = (count == '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tcce_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tcce_pkg::QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + tcce_pkg::QCNT_W'(1);
        2'b01:   count <= count - tcce_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/tcce_back.sv =====
`default_nettype none

// Carries out commands on the screen store and holds the result register.
module tcce_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tcce_pkg::ATTR_W-1:0]   blank_attr,
  input  logic                          q_empty,
  input  tcce_pkg::cmd_t                cmd,
  output logic                          pop,
  output logic                          init_done,
  tcce_rsp_if.source                    rsp
);

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_CLEAR  = 5'b10000
  } state_t;

  state_t                          state, state_next;
  logic [tcce_pkg::CNT_W-1:0]      cnt, cnt_next;
  tcce_pkg::cmd_t                  cur, cur_next;

  logic [tcce_pkg::CELL_W-1:0]     mem [tcce_pkg::CELLS];
  logic                            mem_we;
  logic [tcce_pkg::ADDR_W-1:0]     mem_waddr;
  logic [tcce_pkg::CELL_W-1:0]     mem_wdata;
  logic [tcce_pkg::ADDR_W-1:0]     mem_raddr;
  logic [tcce_pkg::CELL_W-1:0]     rdata;

  logic                            out_valid;
  logic                            out_free;
  logic                            load;
  logic [tcce_pkg::CELL_W-1:0]     load_cell;
  logic [tcce_pkg::COL_W-1:0]      load_col;
  logic [tcce_pkg::ROW_W-1:0]      load_row;
  logic                            load_scrolled;
  logic [tcce_pkg::CELL_W-1:0]     blank;
  logic [tcce_pkg::CNT_W-1:0]      cnt_m1;

  assign blank     = {blank_attr, tcce_pkg::SPACE_CHAR};
  assign out_free  = !out_valid || rsp.ready;
  assign init_done = (state != ST_INIT);
  assign cnt_m1    = cnt - tcce_pkg::CNT_W'(1);

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cur_next      = cur;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = blank;
    mem_raddr     = '0;
    load          = 1'b0;
    load_cell     = '0;
    load_col      = cur.col;
    load_row      = cur.row;
    load_scrolled = 1'b0;

    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[tcce_pkg::ADDR_W-1:0];
        mem_wdata = tcce_pkg::RESET_CELL;
        if (cnt == tcce_pkg::CNT_W'(tcce_pkg::CELLS - 1)) begin
          state_next = ST_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + tcce_pkg::CNT_W'(1);
        end
      end
      ST_IDLE: begin
        if (!q_empty && out_free) begin
          pop      = 1'b1;
          cur_next = cmd;
          cnt_next = '0;
          load_col = cmd.col;
          load_row = cmd.row;
          unique case (cmd.kind)
            tcce_pkg::CMD_PUT: begin
              mem_we    = cmd.we;
              mem_waddr = cmd.addr;
              mem_wdata = cmd.wdata;
              if (cmd.scroll) begin
                state_next = ST_SCROLL;
              end else begin
                load = 1'b1;
              end
            end
            tcce_pkg::CMD_CLEAR: begin
              state_next = ST_CLEAR;
            end
            tcce_pkg::CMD_READ: begin
              mem_raddr  = cmd.addr;
              state_next = ST_READ;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        load       = 1'b1;
        load_cell  = rdata;
        state_next = ST_IDLE;
      end
      ST_SCROLL: begin
        // read one row ahead, write the cell fetched in the previous cycle
        if (cnt < tcce_pkg::CNT_W'(tcce_pkg::COPY_CELLS)) begin
          mem_raddr = tcce_pkg::ADDR_W'(cnt + tcce_pkg::CNT_W'(tcce_pkg::SCREEN_COLS));
        end
        if (cnt != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_m1[tcce_pkg::ADDR_W-1:0];
          mem_wdata = (cnt <= tcce_pkg::CNT_W'(tcce_pkg::COPY_CELLS)) ? rdata : blank;
        end
        if (cnt == tcce_pkg::CNT_W'(tcce_pkg::CELLS)) begin
          load          = 1'b1;
          load_scrolled = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cnt_next = cnt + tcce_pkg::CNT_W'(1);
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[tcce_pkg::ADDR_W-1:0];
        if (cnt == tcce_pkg::CNT_W'(tcce_pkg::CELLS - 1)) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + tcce_pkg::CNT_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    if (load) begin
      rsp.cell_value <= load_cell;
      rsp.cursor_col <= load_col;
      rsp.cursor_row <= load_row;
      rsp.scrolled   <= load_scrolled;
    end
  end

  assign rsp.valid = out_valid;

endmodule

`default_nettype wire

// ===== design/text_console_cursor_engine.sv =====
// Text console: a screen store of 25 x 80 cells (attribute:character) and a cursor.
// Channels: cfg writes left margin (0), backspace attribute (1), blank attribute (2);
//   writes are always taken (ready tied high) and must be made while idle.
// req carries one item: put character, clear screen or read one cell.
// rsp returns one result per item: cell value, cursor after the item, scroll flag.
// Front end classifies each item and tracks the cursor in the accept cycle, then
// passes a command through a four-entry queue to the back end, which owns the store.
// Results: put without scroll or no-op is loaded into rsp as the back end pops it; read
//   goes through the registered memory read first; put that scrolls is popped, then one
//   cell copied or blanked per cycle on the single write port; clear blanks likewise.
// Throughput: one put per cycle while no scroll occurs and rsp.ready stays high; long
//   operations hold the back end and the queue fills, then req.ready drops.
// Reset: cursor home, registers to 0/7/7, then a clearing pass fills the store with
//   blank spaces; req.ready stays low until it ends.
// Receiver stall: the result is held in rsp; the back end waits, the queue fills,
//   and input is back-pressured. No result is lost or repeated.
`default_nettype none

module text_console_cursor_engine (
  input  logic        clk,
  input  logic        rst,
  tcce_cfg_if.sink    cfg,
  tcce_req_if.sink    req,
  tcce_rsp_if.source  rsp
);

  // configuration registers
  logic [tcce_pkg::COL_W-1:0]   left_margin;
  logic [tcce_pkg::ATTR_W-1:0]  default_attr;
  logic [tcce_pkg::ATTR_W-1:0]  blank_attr;

  // queue hookup
  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  logic            init_done;
  tcce_pkg::cmd_t  q_din;
  tcce_pkg::cmd_t  q_dout;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_margin  <= '0;
      default_attr <= tcce_pkg::RESET_ATTR;
      blank_attr   <= tcce_pkg::RESET_ATTR;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        tcce_pkg::CFG_LEFT_MARGIN:  left_margin  <= cfg.data[tcce_pkg::COL_W-1:0];
        tcce_pkg::CFG_DEFAULT_ATTR: default_attr <= cfg.data;
        tcce_pkg::CFG_BLANK_ATTR:   blank_attr   <= cfg.data;
        default: ;  // unused index: write dropped
      endcase
    end
  end

  // front end: cursor tracking and classification
  tcce_front u_front (
    .clk          (clk),
    .rst          (rst),
    .left_margin  (left_margin),
    .default_attr (default_attr),
    .q_full       (q_full),
    .init_done    (init_done),
    .req          (req),
    .push         (q_push),
    .cmd          (q_din)
  );

  tcce_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  // back end: screen store, scroll and clear sweeps, result register
  tcce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .blank_attr (blank_attr),
    .q_empty    (q_empty),
    .cmd        (q_dout),
    .pop        (q_pop),
    .init_done  (init_done),
    .rsp        (rsp)
  );

  // no transfer in while the store is still being cleared after reset
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (rst)
    !init_done |-> !(req.valid && req.ready))
    else $error("item taken during clearing pass");

  // a scrolled result always leaves the cursor on the last row
  a_scroll_last_row: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.scrolled) |->
      (rsp.cursor_row == tcce_pkg::ROW_W'(tcce_pkg::SCREEN_ROWS - 1)))
    else $error("scroll left cursor off the last row");

  // results never carry a cursor outside the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.cursor_col < tcce_pkg::COL_W'(tcce_pkg::SCREEN_COLS) &&
                   rsp.cursor_row < tcce_pkg::ROW_W'(tcce_pkg::SCREEN_ROWS)))
    else $error("cursor out of range");

  // the queue is never pushed while full nor popped while empty
  a_queue_safe: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full) && !(q_pop && q_empty))
    else $error("command queue overrun");

endmodule

`default_nettype wire

// ===== bench/tb_text_console_cursor_engine.sv =====
`default_nettype none

module tb_text_console_cursor_engine;
  import tcce_pkg::*;

  // action code 3 has no meaning and must leave everything untouched
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
  // long receiver hold-off used to fill the command queue
  localparam int HOLD_CYCLES  = 400;
  // quiet time after the last result: longer than a scroll or a clear
  localparam int DRAIN_CYCLES = 2100;

  typedef struct packed {
    logic [CELL_W-1:0] cell_value;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic              scrolled;
  } console_out_t;

  logic clk;
  logic rst;

  tcce_req_if req_ch ();
  tcce_rsp_if rsp_ch ();
  tcce_cfg_if cfg_ch ();

  text_console_cursor_engine i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the console: screen store, cursor and the three registers.
  // The cursor is kept as int so that a column of 80 (before the wrap) is legal.
  // ---------------------------------------------------------------------------
  logic [CELL_W-1:0] screen_mirror [CELLS];
  int                cur_col;
  int                cur_row;
  logic [COL_W-1:0]  margin_q;
  logic [ATTR_W-1:0] bs_attr_q;
  logic [ATTR_W-1:0] blank_attr_q;
  logic              scroll_seen;

  console_out_t cursor_results_q [$];   // outstanding results, oldest first
  int           fail_count;
  int           items_sent;

  // idling controls shared by the sender, the receiver pacer and the tests
  bit src_gaps;
  bit snk_stalls;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous ceiling: every item scrolling, full idling on both sides, plus
  // the clearing pass after reset, taken about five times over.
  initial begin
    #(80_000_000);
    $display("FAILURE");
    $finish;
  end

  function automatic void blank_screen();
    int i;
    for (i = 0; i < CELLS; i++) screen_mirror[i] = {blank_attr_q, SPACE_CHAR};
  endfunction

  // Wrap past the last column, then scroll one row if past the last row.
  // The cursor row stays on the bottom line after a scroll.
  function automatic void wrap_and_scroll_mirror();
    int i;
    if (cur_col >= SCREEN_COLS) begin
      cur_col = 0;
      cur_row++;
    end
    if (cur_row >= SCREEN_ROWS) begin
      for (i = 0; i < COPY_CELLS; i++) screen_mirror[i] = screen_mirror[i + SCREEN_COLS];
      for (i = COPY_CELLS; i < CELLS; i++) screen_mirror[i] = {blank_attr_q, SPACE_CHAR};
      cur_row     = SCREEN_ROWS - 1;
      scroll_seen = 1'b1;
    end
  endfunction

  function automatic void write_at_cursor(input logic [CHAR_W-1:0] ch,
                                          input logic [ATTR_W-1:0] attr);
    if (cur_row < SCREEN_ROWS && cur_col < SCREEN_COLS)
      screen_mirror[cur_row * SCREEN_COLS + cur_col] = {attr, ch};
    cur_col++;
    wrap_and_scroll_mirror();
  endfunction

  function automatic void apply_char(input logic [CHAR_W-1:0] ch,
                                     input logic [ATTR_W-1:0] attr);
    case (ch)
      CH_TAB: cur_col = ((cur_col + TAB_STOP) / TAB_STOP) * TAB_STOP;
      CH_CR:  cur_col = 0;
      CH_LF: begin
        cur_col = 0;
        cur_row++;
      end
      CH_BS: begin
        // the blank is printed like a space, so the cursor steps forward and
        // back again; at a margin on the last column it wraps and stays there
        if (cur_col > int'(margin_q)) cur_col--;
        write_at_cursor(SPACE_CHAR, bs_attr_q);
        if (cur_col > int'(margin_q)) cur_col--;
      end
      default: begin
        // other control bytes are dropped
        if (ch >= SPACE_CHAR) write_at_cursor(ch, attr);
      end
    endcase
    wrap_and_scroll_mirror();
  endfunction

  function automatic console_out_t predict_console(input logic [ACTION_W-1:0] act,
                                                   input logic [CHAR_W-1:0]   ch,
                                                   input logic [ATTR_W-1:0]   color,
                                                   input logic [ROW_W-1:0]    row,
                                                   input logic [COL_W-1:0]    col);
    console_out_t res;
    res         = '0;
    scroll_seen = 1'b0;
    case (act)
      ACT_PUT:   apply_char(ch, color);
      ACT_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      ACT_READ: begin
        // reads off the screen return zero
        if (row < SCREEN_ROWS && col < SCREEN_COLS)
          res.cell_value = screen_mirror[int'(row) * SCREEN_COLS + int'(col)];
      end
      default: ;
    endcase
    res.cursor_col = cur_col[COL_W-1:0];
    res.cursor_row = cur_row[ROW_W-1:0];
    res.scrolled   = scroll_seen;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every transfer on rsp is matched against the oldest
  // outstanding prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    console_out_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (cursor_results_q.size() == 0) begin
        $error("result with nothing outstanding: cell_value %h col %0d row %0d",
               rsp_ch.cell_value, rsp_ch.cursor_col, rsp_ch.cursor_row);
        fail_count++;
      end else begin
        want = cursor_results_q.pop_front();
        if (rsp_ch.cell_value !== want.cell_value) begin
          $error("cell_value: expected %h, got %h", want.cell_value, rsp_ch.cell_value);
          fail_count++;
        end
        if (rsp_ch.cursor_col !== want.cursor_col) begin
          $error("cursor_col: expected %0d, got %0d", want.cursor_col, rsp_ch.cursor_col);
          fail_count++;
        end
        if (rsp_ch.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, rsp_ch.cursor_row);
          fail_count++;
        end
        if (rsp_ch.scrolled !== want.scrolled) begin
          $error("scrolled: expected %0b, got %0b", want.scrolled, rsp_ch.scrolled);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver pacer: random stall bursts while snk_stalls is set, and one long
  // hold-off on request, counted here so the sender keeps offering meanwhile.
  // ---------------------------------------------------------------------------
  initial begin : rsp_pacer
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (snk_stalls && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // One request transfer. valid is left high on return so back-to-back items
  // need no second assignment in the same step; a source gap lowers it first.
  task automatic send_item(input logic [ACTION_W-1:0] act,
                           input logic [CHAR_W-1:0]   ch,
                           input logic [ATTR_W-1:0]   color,
                           input logic [ROW_W-1:0]    row,
                           input logic [COL_W-1:0]    col);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= act;
    req_ch.char_code <= ch;
    req_ch.color     <= color;
    req_ch.read_row  <= row;
    req_ch.read_col  <= col;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    cursor_results_q.push_back(predict_console(act, ch, color, row, col));
    items_sent++;
  endtask

  // Put a character; the read fields carry random noise the block must ignore.
  task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [ATTR_W-1:0] color);
    send_item(ACT_PUT, ch, color, ROW_W'($urandom_range(0, 31)),
              COL_W'($urandom_range(0, 127)));
  endtask

  task automatic read_cell(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    send_item(ACT_READ, CHAR_W'($urandom_range(0, 255)), ATTR_W'($urandom_range(0, 255)),
              row, col);
  endtask

  // Idle: no request offered, every result back, and ready up (this also
  // covers the clearing pass after reset).
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (cursor_results_q.size() != 0 || !req_ch.ready) @(posedge clk);
  endtask

  // Write all three registers back to back, only once the block is idle.
  task automatic set_registers(input logic [CFG_DATA_W-1:0] margin,
                               input logic [CFG_DATA_W-1:0] bs_attr,
                               input logic [CFG_DATA_W-1:0] blank_attr);
    logic [CFG_DATA_W-1:0] vals [3];
    logic [CFG_IDX_W-1:0]  idx  [3];
    int i;
    vals = '{margin, bs_attr, blank_attr};
    idx  = '{CFG_LEFT_MARGIN, CFG_DEFAULT_ATTR, CFG_BLANK_ATTR};
    wait_idle();
    cfg_ch.valid <= 1'b1;
    for (i = 0; i < 3; i++) begin
      cfg_ch.index <= idx[i];
      cfg_ch.data  <= vals[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      case (idx[i])
        CFG_LEFT_MARGIN:  margin_q     = vals[i][COL_W-1:0];
        CFG_DEFAULT_ATTR: bs_attr_q    = vals[i];
        CFG_BLANK_ATTR:   blank_attr_q = vals[i];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Fresh store after reset: corners blank, off-screen reads zero, spare code inert.
  task automatic test_reset_state();
    read_cell('0, '0);
    read_cell(ROW_W'(SCREEN_ROWS - 1), COL_W'(SCREEN_COLS - 1));
    read_cell(ROW_W'(SCREEN_ROWS), '0);
    read_cell('0, COL_W'(SCREEN_COLS));
    read_cell(5'd31, 7'd127);
    send_item(ACT_SPARE, 8'hFF, 8'hFF, 5'd31, 7'd127);
  endtask

  // Printable extremes, tab stops, return, line feed, backspace and dropped
  // control bytes, then read back what landed in row 0.
  task automatic test_control_chars();
    put_char(SPACE_CHAR, 8'h00);
    put_char(8'hFF, 8'hFF);
    put_char("Z", 8'h1E);
    put_char(CH_TAB, 8'h55);
    put_char(CH_TAB, 8'hAA);
    put_char(CH_BS, 8'h33);
    put_char(8'h00, 8'hFF);
    put_char(8'h1F, 8'h00);
    put_char(CH_CR, 8'h12);
    put_char(CH_LF, 8'h34);
    read_cell('0, 7'd1);
    read_cell('0, 7'd7);
  endtask

  // Register extremes: margin beyond the screen width (backspace never moves
  // left), backspace colour and blank colour through clear, margin at zero.
  task automatic test_registers();
    set_registers(8'hFF, 8'hFF, 8'h00);
    send_item(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)), ATTR_W'($urandom_range(0, 255)),
              ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
    put_char("A", 8'hC3);
    put_char(CH_BS, 8'h00);
    read_cell('0, '0);
    read_cell('0, 7'd1);
    read_cell(ROW_W'(SCREEN_ROWS - 1), COL_W'(SCREEN_COLS - 1));
    set_registers(8'h00, 8'h5A, 8'hA5);
    put_char(CH_CR, 8'h00);
    put_char(CH_BS, 8'hFF);
    read_cell('0, '0);
  endtask

  // Receiver holds off for a long stretch while the sender keeps going, so the
  // queue fills and req.ready must drop without losing a transfer.
  task automatic test_backpressure();
    int i;
    wait_idle();
    src_gaps   = 1'b0;
    snk_stalls = 1'b0;
    hold_req   = 1'b1;
    for (i = 0; i < 30; i++) begin
      if (i % 6 == 5) read_cell(ROW_W'(cur_row), COL_W'($urandom_range(0, SCREEN_COLS - 1)));
      else if (i % 10 == 9) put_char(CH_LF, ATTR_W'($urandom_range(0, 255)));
      else put_char(CHAR_W'($urandom_range(32, 255)), ATTR_W'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------------

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)      put_char(CHAR_W'($urandom_range(32, 255)),
                                 ATTR_W'($urandom_range(0, 255)));
    else if (pick < 63) put_char(CH_LF, ATTR_W'($urandom_range(0, 255)));
    else if (pick < 67) put_char(CH_CR, ATTR_W'($urandom_range(0, 255)));
    else if (pick < 71) put_char(CH_TAB, ATTR_W'($urandom_range(0, 255)));
    else if (pick < 77) put_char(CH_BS, ATTR_W'($urandom_range(0, 255)));
    else if (pick < 80) put_char(CHAR_W'($urandom_range(0, 31)),
                                 ATTR_W'($urandom_range(0, 255)));
    else if (pick < 86) read_cell(ROW_W'(cur_row), COL_W'($urandom_range(0, SCREEN_COLS - 1)));
    else if (pick < 91) read_cell(ROW_W'($urandom_range(0, SCREEN_ROWS - 1)),
                                  COL_W'($urandom_range(0, SCREEN_COLS - 1)));
    else if (pick < 93) read_cell(ROW_W'($urandom_range(0, 31)),
                                  COL_W'($urandom_range(0, 127)));
    else if (pick < 95) send_item(ACT_SPARE, CHAR_W'($urandom_range(0, 255)),
                                  ATTR_W'($urandom_range(0, 255)),
                                  ROW_W'($urandom_range(0, 31)),
                                  COL_W'($urandom_range(0, 127)));
    else if (pick < 96) send_item(ACT_CLEAR, CHAR_W'($urandom_range(0, 255)),
                                  ATTR_W'($urandom_range(0, 255)),
                                  ROW_W'($urandom_range(0, 31)),
                                  COL_W'($urandom_range(0, 127)));
    else send_item(ACTION_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                   ATTR_W'($urandom_range(0, 255)), ROW_W'($urandom_range(0, 31)),
                   COL_W'($urandom_range(0, 127)));
  endtask

  // Mostly single items; sometimes a run of tabs up to the right edge followed
  // by backspace or text (wrap at the last column), a run of line feeds down
  // to the bottom (scrolling), or a long line that wraps.
  task automatic send_random_burst();
    int pick;
    logic [CHAR_W-1:0] ch;
    pick = $urandom_range(0, 99);
    if (pick < 86) begin
      send_random_item();
    end else if (pick < 92) begin
      repeat ($urandom_range(10, 20)) put_char(CH_TAB, ATTR_W'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 3)) begin
        ch = $urandom_range(0, 1) ? CH_BS : 8'($urandom_range(32, 255));
        put_char(ch, ATTR_W'($urandom_range(0, 255)));
      end
      read_cell(ROW_W'(cur_row), COL_W'($urandom_range(SCREEN_COLS - 4, SCREEN_COLS - 1)));
    end else if (pick < 97) begin
      repeat ($urandom_range(5, 26)) put_char(CH_LF, ATTR_W'($urandom_range(0, 255)));
      read_cell(ROW_W'(SCREEN_ROWS - 1), COL_W'($urandom_range(0, SCREEN_COLS - 1)));
    end else begin
      repeat ($urandom_range(60, 100))
        put_char(CHAR_W'($urandom_range(32, 255)), ATTR_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_phase(input int target,
                                   input logic [CFG_DATA_W-1:0] margin,
                                   input logic [CFG_DATA_W-1:0] bs_attr,
                                   input logic [CFG_DATA_W-1:0] blank_attr,
                                   input bit gaps, input bit stalls);
    int start;
    set_registers(margin, bs_attr, blank_attr);
    src_gaps   = gaps;
    snk_stalls = stalls;
    start      = items_sent;
    while (items_sent - start < target) send_random_burst();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.action    <= ACT_PUT;
    req_ch.char_code <= '0;
    req_ch.color     <= '0;
    req_ch.read_row  <= '0;
    req_ch.read_col  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_LEFT_MARGIN;
    cfg_ch.data      <= '0;
    src_gaps     = 1'b1;
    snk_stalls   = 1'b1;
    hold_req     = 1'b0;
    fail_count   = 0;
    items_sent   = 0;
    margin_q     = '0;
    bs_attr_q    = RESET_ATTR;
    blank_attr_q = RESET_ATTR;
    cur_col      = 0;
    cur_row      = 0;
    scroll_seen  = 1'b0;
    blank_screen();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_control_chars();
    test_registers();
    test_backpressure();

    // margins: zero, beyond the width, last column, random, just past the width
    test_random_phase(115, 8'h00, 8'h07, 8'h07, 1'b1, 1'b1);
    test_random_phase(115, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b0);
    test_random_phase(115, 8'd79, 8'hFF, 8'h00, 1'b0, 1'b1);
    test_random_phase(115, CFG_DATA_W'($urandom_range(0, 255)),
                      CFG_DATA_W'($urandom_range(0, 255)),
                      CFG_DATA_W'($urandom_range(0, 255)), 1'b1, 1'b1);
    test_random_phase(115, 8'd80, CFG_DATA_W'($urandom_range(0, 255)),
                      CFG_DATA_W'($urandom_range(0, 255)), 1'b1, 1'b1);
    // closing stretch runs flat out on both sides
    test_random_phase(115, CFG_DATA_W'($urandom_range(0, 79)),
                      CFG_DATA_W'($urandom_range(0, 255)),
                      CFG_DATA_W'($urandom_range(0, 255)), 1'b0, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
design/tcce_pkg.sv
design/tcce_if.sv
design/tcce_front.sv
design/tcce_queue.sv
design/tcce_back.sv
design/text_console_cursor_engine.sv
bench/tb_text_console_cursor_engine.sv
